// ===== rtl/core/bds_pkg.sv =====
// Shared types, widths, constants and tables for the baud divisor search block.
package bds_pkg;

	localparam int BAUD_W      = 20;
	localparam int CLOCK_W     = 27;
	localparam int MAXERR_W    = 14;
	localparam int REG_W       = 16;
	localparam int IDX_W       = 4;
	localparam int ACT_W       = 26;
	localparam int ERR_W       = 15;
	localparam int MAG_W       = 14;
	localparam int SCALED_W    = 40;
	localparam int LIMIT_W     = 34;
	localparam int CHK_W       = 28;
	localparam int DIVIDEND_W  = 40;
	localparam int DIVISOR_W   = 20;
	localparam int DIV_CNT_W   = $clog2(DIVIDEND_W);
	localparam int S_TDATA_W   = 24;
	localparam int M_TDATA_W   = 88;
	localparam int PADDR_W     = 3;
	localparam int PDATA_W     = 32;

	localparam int RATE_COUNT  = 9;

	localparam logic [CLOCK_W-1:0]  CLOCK_RESET  = CLOCK_W'(16000000);
	localparam logic [MAXERR_W-1:0] MAXERR_RESET = MAXERR_W'(200);

	localparam logic [MAXERR_W-1:0] ERR_SCALE = MAXERR_W'(10000);
	localparam logic [MAG_W-1:0]    ERR_SAT   = MAG_W'(10000);

	// Register index as seen on paddr[2].
	localparam logic REG_CLOCK  = 1'b0;
	localparam logic REG_MAXERR = 1'b1;

	// Generator modes in trial order: 8-bit /64, 8-bit /16, 16-bit /16, 16-bit /4.
	// Bit 1 selects the wide generator, bit 0 the high speed divider.
	localparam logic [1:0] MODE_FIRST = 2'd0;
	localparam logic [1:0] MODE_LAST  = 2'd3;

	localparam logic [DIVIDEND_W-1:0] NARROW_LIMIT = DIVIDEND_W'(256);
	localparam logic [DIVIDEND_W-1:0] WIDE_LIMIT   = DIVIDEND_W'(65536);

	typedef enum logic [1:0] {
		DIV_OP_Q,
		DIV_OP_ACT,
		DIV_OP_MAG
	} div_op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV_Q,
		ST_DIV_ACT,
		ST_MUL,
		ST_CMP,
		ST_DIV_MAG,
		ST_NEXT,
		ST_FOUND,
		ST_MISS
	} state_t;

	typedef struct packed {
		logic    load_req;
		logic    next_rate;
		logic    inc_mode;
		logic    div_start;
		div_op_t div_op;
		logic    latch_reg;
		logic    latch_act;
		logic    latch_mul;
		logic    latch_mag;
		logic    load_out;
		logic    out_found;
	} ctl_cmd_t;

	typedef struct packed {
		logic range_ok;
		logic reg_ok;
		logic err_ok;
		logic div_done;
		logic mode_last;
		logic rate_last;
		logic search;
		logic out_busy;
	} ctl_stat_t;

	// Standard rate table, fastest first.
	function automatic logic [BAUD_W-1:0] rate_of(input logic [IDX_W-1:0] idx);
		logic [BAUD_W-1:0] r;
		case (idx)
			4'd0: r = BAUD_W'(115200);
			4'd1: r = BAUD_W'(57600);
			4'd2: r = BAUD_W'(38400);
			4'd3: r = BAUD_W'(19200);
			4'd4: r = BAUD_W'(9600);
			4'd5: r = BAUD_W'(4800);
			4'd6: r = BAUD_W'(2400);
			4'd7: r = BAUD_W'(1200);
			4'd8: r = BAUD_W'(300);
			default: r = '0;
		endcase
		return r;
	endfunction

	// Log2 of the generator prescaler for each mode.
	function automatic logic [2:0] mode_shift(input logic [1:0] mode);
		logic [2:0] s;
		case (mode)
			2'd0: s = 3'd6;
			2'd1: s = 3'd4;
			2'd2: s = 3'd4;
			2'd3: s = 3'd2;
			default: s = 3'd2;
		endcase
		return s;
	endfunction

endpackage

// ===== rtl/core/bds_divider.sv =====
// Restoring divider that produces one quotient bit per clock.
module bds_divider (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [bds_pkg::DIVIDEND_W-1:0]      dividend,
	input  logic [bds_pkg::DIVISOR_W-1:0]       divisor,
	output logic                                done,
	output logic [bds_pkg::DIVIDEND_W-1:0]      quotient
);

	logic                                busy_q;
	logic                                done_q;
	logic [bds_pkg::DIV_CNT_W-1:0]       cnt_q;
	logic [bds_pkg::DIVIDEND_W-1:0]      quo_q;
	logic [bds_pkg::DIVISOR_W-1:0]       rem_q;
	logic [bds_pkg::DIVISOR_W-1:0]       dsr_q;
	logic [bds_pkg::DIVISOR_W:0]         trial;
	logic [bds_pkg::DIVISOR_W:0]         diff;
	logic                                ge;

	assign trial = {rem_q, quo_q[bds_pkg::DIVIDEND_W-1]};
	assign ge    = trial >= {1'b0, dsr_q};
	assign diff  = trial - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= bds_pkg::DIV_CNT_W'(bds_pkg::DIVIDEND_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[bds_pkg::DIVIDEND_W-2:0], ge};
			rem_q <= ge ? diff[bds_pkg::DIVISOR_W-1:0] : trial[bds_pkg::DIVISOR_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== rtl/core/bds_datapath.sv =====
// Datapath: trial operands, shared divider, error arithmetic and result register.
module bds_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  bds_pkg::ctl_cmd_t                   cmd,
	output bds_pkg::ctl_stat_t                  stat,
	input  logic [bds_pkg::CLOCK_W-1:0]         clock_hz,
	input  logic [bds_pkg::MAXERR_W-1:0]        max_err,
	input  logic [bds_pkg::BAUD_W-1:0]          requested_baud,
	input  logic                                search_table,
	input  logic                                m_tready,
	output logic                                m_tvalid,
	output logic [bds_pkg::M_TDATA_W-1:0]       m_tdata,
	output logic                                m_tuser
);

	logic                                search_q;
	logic [bds_pkg::IDX_W-1:0]           idx_q;
	logic [1:0]                          mode_q;
	logic [bds_pkg::BAUD_W-1:0]          baud_q;
	logic [bds_pkg::REG_W-1:0]           reg_q;
	logic [bds_pkg::ACT_W-1:0]           actual_q;
	logic [bds_pkg::SCALED_W-1:0]        scaled_q;
	logic [bds_pkg::LIMIT_W-1:0]         limit_q;
	logic                                neg_q;
	logic [bds_pkg::MAG_W-1:0]           mag_q;
	logic                                out_valid_q;
	logic [bds_pkg::M_TDATA_W-1:0]       out_data_q;
	logic                                out_found_q;

	logic [2:0]                          shift;
	logic [bds_pkg::CLOCK_W-1:0]         clk_sh;
	logic [bds_pkg::CHK_W-1:0]           prod2;
	logic [bds_pkg::DIVIDEND_W-1:0]      div_dividend;
	logic [bds_pkg::DIVISOR_W-1:0]       div_divisor;
	logic                                div_done;
	logic [bds_pkg::DIVIDEND_W-1:0]      quot;
	logic [bds_pkg::DIVIDEND_W-1:0]      reg_limit;
	logic [bds_pkg::ACT_W-1:0]           baud_ext;
	logic                                neg;
	logic [bds_pkg::ACT_W-1:0]           diff;
	logic [bds_pkg::SCALED_W-1:0]        scaled_d;
	logic [bds_pkg::LIMIT_W-1:0]         limit_d;
	logic [bds_pkg::MAG_W-1:0]           mag_d;
	logic [bds_pkg::ERR_W-1:0]           err;
	logic [bds_pkg::IDX_W-1:0]           idx_next;

	assign shift  = bds_pkg::mode_shift(mode_q);
	assign clk_sh = clock_hz >> shift;
	// The range check compares the clock against twice the prescaled rate.
	assign prod2  = bds_pkg::CHK_W'(baud_q) << (shift + 3'd1);

	always_comb begin
		case (cmd.div_op)
			bds_pkg::DIV_OP_Q: begin
				div_dividend = bds_pkg::DIVIDEND_W'(clk_sh);
				div_divisor  = baud_q;
			end
			bds_pkg::DIV_OP_ACT: begin
				// The previous quotient is still held by the divider at this start.
				div_dividend = bds_pkg::DIVIDEND_W'(clk_sh);
				div_divisor  = quot[bds_pkg::DIVISOR_W-1:0];
			end
			bds_pkg::DIV_OP_MAG: begin
				div_dividend = scaled_q;
				div_divisor  = baud_q;
			end
			default: begin
				div_dividend = scaled_q;
				div_divisor  = baud_q;
			end
		endcase
	end

	bds_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (quot)
	);

	assign reg_limit = mode_q[1] ? bds_pkg::WIDE_LIMIT : bds_pkg::NARROW_LIMIT;
	assign baud_ext  = bds_pkg::ACT_W'(baud_q);
	assign neg       = actual_q < baud_ext;
	assign diff      = neg ? (baud_ext - actual_q) : (actual_q - baud_ext);
	assign scaled_d  = bds_pkg::SCALED_W'(diff) * bds_pkg::SCALED_W'(bds_pkg::ERR_SCALE);
	assign limit_d   = bds_pkg::LIMIT_W'(max_err) * bds_pkg::LIMIT_W'(baud_q);
	assign mag_d     = (quot > bds_pkg::DIVIDEND_W'(bds_pkg::ERR_SAT)) ? bds_pkg::ERR_SAT
		: quot[bds_pkg::MAG_W-1:0];
	assign err       = neg_q ? (bds_pkg::ERR_W'(0) - bds_pkg::ERR_W'(mag_q))
		: bds_pkg::ERR_W'(mag_q);
	assign idx_next  = idx_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			search_q <= search_table;
			idx_q    <= '0;
			mode_q   <= bds_pkg::MODE_FIRST;
			baud_q   <= search_table ? bds_pkg::rate_of('0) : requested_baud;
		end else if (cmd.next_rate) begin
			idx_q  <= idx_next;
			mode_q <= bds_pkg::MODE_FIRST;
			baud_q <= bds_pkg::rate_of(idx_next);
		end else if (cmd.inc_mode) begin
			mode_q <= mode_q + 1'b1;
		end
		if (cmd.latch_reg) begin
			reg_q <= quot[bds_pkg::REG_W-1:0] - 1'b1;
		end
		if (cmd.latch_act) begin
			actual_q <= quot[bds_pkg::ACT_W-1:0];
		end
		if (cmd.latch_mul) begin
			scaled_q <= scaled_d;
			limit_q  <= limit_d;
			neg_q    <= neg;
		end
		if (cmd.latch_mag) begin
			mag_q <= mag_d;
		end
		if (cmd.load_out) begin
			out_found_q <= cmd.out_found;
			if (cmd.out_found) begin
				out_data_q <= {5'b0, err, actual_q, baud_q, idx_q, mode_q[0], mode_q[1], reg_q};
			end else begin
				out_data_q <= '0;
			end
		end
	end

	assign stat.range_ok  = (baud_q != '0) && ({1'b0, clock_hz} > prod2);
	assign stat.reg_ok    = quot <= reg_limit;
	assign stat.err_ok    = bds_pkg::SCALED_W'(limit_q) > scaled_q;
	assign stat.div_done  = div_done;
	assign stat.mode_last = mode_q == bds_pkg::MODE_LAST;
	assign stat.rate_last = idx_q == bds_pkg::IDX_W'(bds_pkg::RATE_COUNT - 1);
	assign stat.search    = search_q;
	assign stat.out_busy  = out_valid_q && !m_tready;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_found_q;

endmodule

// ===== rtl/core/bds_ctrl.sv =====
// Controller state machine that sequences rates, modes and divider operations.
module bds_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  bds_pkg::ctl_stat_t   stat,
	output bds_pkg::ctl_cmd_t    cmd
);

	bds_pkg::state_t state_q;
	bds_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bds_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			bds_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load_req = 1'b1;
					state_d      = bds_pkg::ST_CHECK;
				end
			end
			bds_pkg::ST_CHECK: begin
				if (stat.range_ok) begin
					cmd.div_start = 1'b1;
					cmd.div_op    = bds_pkg::DIV_OP_Q;
					state_d       = bds_pkg::ST_DIV_Q;
				end else begin
					state_d = bds_pkg::ST_NEXT;
				end
			end
			bds_pkg::ST_DIV_Q: begin
				if (stat.div_done) begin
					if (stat.reg_ok) begin
						cmd.latch_reg = 1'b1;
						cmd.div_start = 1'b1;
						cmd.div_op    = bds_pkg::DIV_OP_ACT;
						state_d       = bds_pkg::ST_DIV_ACT;
					end else begin
						state_d = bds_pkg::ST_NEXT;
					end
				end
			end
			bds_pkg::ST_DIV_ACT: begin
				if (stat.div_done) begin
					cmd.latch_act = 1'b1;
					state_d       = bds_pkg::ST_MUL;
				end
			end
			bds_pkg::ST_MUL: begin
				cmd.latch_mul = 1'b1;
				state_d       = bds_pkg::ST_CMP;
			end
			bds_pkg::ST_CMP: begin
				if (stat.err_ok) begin
					cmd.div_start = 1'b1;
					cmd.div_op    = bds_pkg::DIV_OP_MAG;
					state_d       = bds_pkg::ST_DIV_MAG;
				end else begin
					state_d = bds_pkg::ST_NEXT;
				end
			end
			bds_pkg::ST_DIV_MAG: begin
				if (stat.div_done) begin
					cmd.latch_mag = 1'b1;
					state_d       = bds_pkg::ST_FOUND;
				end
			end
			bds_pkg::ST_NEXT: begin
				if (!stat.mode_last) begin
					cmd.inc_mode = 1'b1;
					state_d      = bds_pkg::ST_CHECK;
				end else if (stat.search && !stat.rate_last) begin
					cmd.next_rate = 1'b1;
					state_d       = bds_pkg::ST_CHECK;
				end else begin
					state_d = bds_pkg::ST_MISS;
				end
			end
			bds_pkg::ST_FOUND: begin
				if (!stat.out_busy) begin
					cmd.load_out  = 1'b1;
					cmd.out_found = 1'b1;
					state_d       = bds_pkg::ST_IDLE;
				end
			end
			bds_pkg::ST_MISS: begin
				if (!stat.out_busy) begin
					cmd.load_out = 1'b1;
					state_d      = bds_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = bds_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/core/uart_baud_divisor_search_top.sv =====
// Top level of the baud divisor search: register file, controller and datapath.
//
// A request enters on the slave stream: s_tdata holds the requested baud rate and
// s_tuser selects a search of the standard rate table (115200 down to 300) instead.
// For each rate the block tries the 8-bit /64, 8-bit /16, 16-bit /16 and 16-bit /4
// generator modes in turn and returns one result on the master stream: m_tuser
// tells whether a setting within tolerance was found, m_tdata carries the setting.
// Requests are handled one at a time. Every quotient comes from one shared
// bit-serial divider, which sets the latency: a mode that fails the range check
// needs no division, one that fails the register size needs one, one that fails
// the error check two, and the accepted one three before its result is loaded.
// The clock and tolerance registers sit on the APB port at byte offsets 0 and 4 and
// reset to 16 MHz and 2.00 percent; they should be written only while idle.
// A finished result waits in the output register while the next request is taken;
// if the receiver still stalls when that request completes, the block waits.
// Reset clears the controller and the output valid flag.
module uart_baud_divisor_search_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// [19:0] requested_baud, [23:20] zero
	input  logic [bds_pkg::S_TDATA_W-1:0]     s_tdata,
	// [0] search_table
	input  logic                              s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// [15:0] divisor_value, [16] wide_generator, [17] high_speed, [21:18] rate_index,
	// [41:22] target_baud, [67:42] actual_baud, [82:68] error_hundredths, [87:83] zero
	output logic [bds_pkg::M_TDATA_W-1:0]     m_tdata,
	// [0] found
	output logic                              m_tuser,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [bds_pkg::PADDR_W-1:0]       paddr,
	input  logic [bds_pkg::PDATA_W-1:0]       pwdata,
	output logic [bds_pkg::PDATA_W-1:0]       prdata,
	output logic                              pready
);

	logic [bds_pkg::CLOCK_W-1:0]   clock_hz_q;
	logic [bds_pkg::MAXERR_W-1:0]  max_err_q;
	logic                          wr_en;
	bds_pkg::ctl_cmd_t             cmd;
	bds_pkg::ctl_stat_t            stat;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_hz_q <= bds_pkg::CLOCK_RESET;
			max_err_q  <= bds_pkg::MAXERR_RESET;
		end else if (wr_en) begin
			case (paddr[2])
				bds_pkg::REG_CLOCK:  clock_hz_q <= pwdata[bds_pkg::CLOCK_W-1:0];
				bds_pkg::REG_MAXERR: max_err_q  <= pwdata[bds_pkg::MAXERR_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			bds_pkg::REG_CLOCK:  prdata = bds_pkg::PDATA_W'(clock_hz_q);
			bds_pkg::REG_MAXERR: prdata = bds_pkg::PDATA_W'(max_err_q);
			default:             prdata = '0;
		endcase
	end

	bds_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	bds_datapath u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.clock_hz       (clock_hz_q),
		.max_err        (max_err_q),
		.requested_baud (s_tdata[bds_pkg::BAUD_W-1:0]),
		.search_table   (s_tuser),
		.m_tready       (m_tready),
		.m_tvalid       (m_tvalid),
		.m_tdata        (m_tdata),
		.m_tuser        (m_tuser)
	);

	// A request keeps the block busy for at least the cycle after its transfer.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted while a request was in progress");

	// A result without a setting carries all-zero data.
	a_miss_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata == '0)
		else $error("not-found result has nonzero data");

	// An accepted setting always has a reload value of at least one.
	a_found_reload: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[15:0] != 16'd0)
		else $error("found result with zero reload value");

	// The reported error stays within plus or minus 100 percent.
	a_err_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |->
			($signed(m_tdata[82:68]) <= 15'sd10000) &&
			($signed(m_tdata[82:68]) >= -15'sd10000))
		else $error("error field out of range");

endmodule

// ===== bench/bds_setting_scoreboard.sv =====
// Scoreboard for the baud divisor search: predicts every generator setting and checks the results.
module bds_setting_scoreboard
	import bds_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	input  logic                   s_tready,
	input  logic [S_TDATA_W-1:0]   s_tdata,
	input  logic                   s_tuser,
	input  logic                   m_tvalid,
	input  logic                   m_tready,
	input  logic [M_TDATA_W-1:0]   m_tdata,
	input  logic                   m_tuser,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [PADDR_W-1:0]     paddr,
	input  logic [PDATA_W-1:0]     pwdata,
	input  logic                   pready,
	output int unsigned            fail_count,
	output int unsigned            pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MODE_COUNT = 4;
	localparam int TABLE_LEN  = 9;

	typedef struct packed {
		logic                     found;
		logic [REG_W-1:0]         divisor;
		logic                     wide;
		logic                     fast;
		logic [IDX_W-1:0]         rate_idx;
		logic [BAUD_W-1:0]        target;
		logic [ACT_W-1:0]         actual;
		logic signed [ERR_W-1:0]  err;
	} setting_t;

	logic [CLOCK_W-1:0]  clock_hz;
	logic [MAXERR_W-1:0] tolerance;
	setting_t            expected_settings[$];

	function automatic longint unsigned std_rate(input int i);
		case (i)
			0: return 115200;
			1: return 57600;
			2: return 38400;
			3: return 19200;
			4: return 9600;
			5: return 4800;
			6: return 2400;
			7: return 1200;
			default: return 300;
		endcase
	endfunction

	// Generator prescaler for mode m: 8-bit /64, 8-bit /16, 16-bit /16, 16-bit /4.
	function automatic longint unsigned prescale(input int m);
		case (m)
			0: return 64;
			1: return 16;
			2: return 16;
			default: return 4;
		endcase
	endfunction

	function automatic bit try_rate(input longint unsigned rate, input int idx,
			output setting_t s);
		longint unsigned prod, q, reload, act, diff, scaled, mag, cap;
		bit neg;
		int m;
		s = '0;
		if (rate == 0)
			return 0;
		for (m = 0; m < MODE_COUNT; m++) begin
			prod = prescale(m) * rate;
			if (clock_hz <= 2 * prod)
				continue;
			q = clock_hz / prod;
			reload = q - 1;
			cap = (m >= 2) ? 64'hFFFF : 64'hFF;
			if (reload > cap)
				continue;
			act = clock_hz / (prescale(m) * (reload + 1));
			neg = act < rate;
			diff = neg ? rate - act : act - rate;
			scaled = diff * 10000;
			if (!(scaled < tolerance * rate))
				continue;
			mag = scaled / rate;
			if (mag > ERR_SAT)
				mag = ERR_SAT;
			s.found = 1'b1;
			s.divisor = REG_W'(reload);
			s.wide = (m >= 2);
			s.fast = (m % 2 == 1);
			s.rate_idx = IDX_W'(idx);
			s.target = BAUD_W'(rate);
			s.actual = ACT_W'(act);
			s.err = ERR_W'(neg ? 64'd0 - mag : mag);
			return 1;
		end
		return 0;
	endfunction

	function automatic setting_t predict_setting(input logic [BAUD_W-1:0] req,
			input logic search);
		setting_t s;
		int i;
		if (search) begin
			for (i = 0; i < RATE_COUNT && i < TABLE_LEN; i++)
				if (try_rate(std_rate(i), i, s))
					return s;
		end else if (try_rate(req, 0, s)) begin
			return s;
		end
		return '0;
	endfunction

	function automatic string describe(input setting_t s);
		return $sformatf({"found=%0d reg=%0d wide=%0d fast=%0d idx=%0d",
			" target=%0d actual=%0d err=%0d"},
			s.found, s.divisor, s.wide, s.fast, s.rate_idx, s.target, s.actual,
			$signed(s.err));
	endfunction

	always @(posedge clk or negedge arst_n) begin
		setting_t got, want;
		if (!arst_n) begin
			clock_hz = CLOCK_RESET;
			tolerance = MAXERR_RESET;
		end else begin
			if (s_tvalid && s_tready)
				expected_settings.push_back(
					predict_setting(s_tdata[BAUD_W-1:0], s_tuser));
			if (m_tvalid && m_tready) begin
				got.found = m_tuser;
				got.divisor = m_tdata[15:0];
				got.wide = m_tdata[16];
				got.fast = m_tdata[17];
				got.rate_idx = m_tdata[21:18];
				got.target = m_tdata[41:22];
				got.actual = m_tdata[67:42];
				got.err = m_tdata[82:68];
				if (expected_settings.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%t unexpected result transfer: %s",
							$realtime, describe(got));
				end else begin
					want = expected_settings.pop_front();
					if (got !== want) begin
						fail_count++;
						if (fail_count <= 10) begin
							$display("%t setting mismatch", $realtime);
							$display("  expected %s", describe(want));
							$display("  actual   %s", describe(got));
						end
					end
				end
			end
			// The user must change the registers only while no request is in flight; the block does not enforce this.
			if (psel && penable && pwrite && pready) begin
				case (paddr[2])
					REG_CLOCK:  clock_hz = pwdata[CLOCK_W-1:0];
					REG_MAXERR: tolerance = pwdata[MAXERR_W-1:0];
					default: ;
				endcase
			end
		end
		pending = expected_settings.size();
	end

endmodule

// ===== bench/uart_baud_divisor_search_top_tb.sv =====
// Testbench top for the baud divisor search: clock, reset, stimulus and verdict.
module uart_baud_divisor_search_top_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import bds_pkg::*;

	localparam int PHASES      = 10;
	localparam int PHASE_ITEMS = 198;
	localparam int HOLD_CYCLES = 1500;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata;
	logic                  s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [M_TDATA_W-1:0]  m_tdata;
	logic                  m_tuser;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [PADDR_W-1:0]    paddr;
	logic [PDATA_W-1:0]    pwdata;
	logic [PDATA_W-1:0]    prdata;
	logic                  pready;

	int unsigned fail_count;
	int unsigned pending;
	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;
	logic        hold_req;
	logic        hold_done;
	logic [CLOCK_W-1:0] cur_clock;

	uart_baud_divisor_search_top DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	bds_setting_scoreboard setting_scoreboard (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.pready     (pready),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#400ms;
		$display("[FAIL] regression broken");
		$finish;
	end

	// Result side: random stalls, plus one long hold-off while requests keep coming.
	initial begin
		int unsigned held;
		held = 0;
		hold_done = 1'b0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && !hold_done) begin
				m_tready = 1'b0;
				held++;
				if (held == HOLD_CYCLES)
					hold_done = 1'b1;
			end else begin
				m_tready = ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	// Offers one request and returns at the edge where it is transferred.
	task automatic send_request(input logic [BAUD_W-1:0] baud, input logic search);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid = 1'b0;
			s_tdata = S_TDATA_W'($urandom);
			s_tuser = 1'($urandom);
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = S_TDATA_W'(baud);
		s_tuser = search;
		do
			@(posedge clk);
		while (!s_tready);
	endtask

	task automatic drain(input int cycles);
		@(negedge clk);
		s_tvalid = 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (cycles) @(negedge clk);
	endtask

	task automatic reg_write(input logic idx, input logic [PDATA_W-1:0] value);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {idx, 2'b00};
		pwdata = value;
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		if (idx == REG_CLOCK)
			cur_clock = value[CLOCK_W-1:0];
	endtask

	task automatic set_config(input logic [CLOCK_W-1:0] hz, input logic [MAXERR_W-1:0] tol,
			input bit junk);
		logic [PDATA_W-1:0] hz_word, tol_word;
		hz_word = PDATA_W'(hz);
		tol_word = PDATA_W'(tol);
		// Bits above the register width must be dropped by the block.
		if (junk) begin
			hz_word[PDATA_W-1:CLOCK_W] = (PDATA_W-CLOCK_W)'($urandom);
			tol_word[PDATA_W-1:MAXERR_W] = (PDATA_W-MAXERR_W)'($urandom);
		end
		drain(16);
		reg_write(REG_CLOCK, hz_word);
		reg_write(REG_MAXERR, tol_word);
	endtask

	function automatic logic [BAUD_W-1:0] random_baud();
		longint unsigned v;
		case ($urandom_range(0, 4))
			0: v = $urandom;
			1: v = rate_of(IDX_W'($urandom_range(0, 8))) + $urandom_range(0, 20) - 10;
			// Rates that a prescaler divides evenly out of the current clock.
			2: v = cur_clock /
				((64'd4 << (2 * $urandom_range(0, 2))) * $urandom_range(1, 600));
			3: v = $urandom_range(0, 2000);
			default: v = $urandom_range(900000, (1 << BAUD_W) - 1);
		endcase
		return BAUD_W'(v);
	endfunction

	initial begin
		int p, n;
		logic [CLOCK_W-1:0] hz;
		logic [MAXERR_W-1:0] tol;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		hold_req = 1'b0;
		send_idle_pct = 25;
		recv_idle_pct = 62;
		cur_clock = CLOCK_RESET;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset settings: table search, field extremes, exact and unreachable rates.
		send_request(BAUD_W'(0), 1'b1);
		send_request(BAUD_W'(0), 1'b0);
		send_request(BAUD_W'(1), 1'b0);
		send_request(BAUD_W'(1000000), 1'b0);
		send_request('1, 1'b0);
		send_request(BAUD_W'(115200), 1'b0);
		send_request(BAUD_W'(250000), 1'b0);
		send_request(BAUD_W'(62500), 1'b0);
		send_request(BAUD_W'(19200), 1'b0);
		send_request(BAUD_W'(9600), 1'b0);
		send_request(BAUD_W'(300), 1'b0);

		// A stopped clock leaves no usable mode.
		set_config('0, MAXERR_W'(200), 0);
		send_request(BAUD_W'(0), 1'b1);
		send_request(BAUD_W'(9600), 1'b0);

		// Zero tolerance rejects even an exact rate.
		set_config(CLOCK_W'(16000000), '0, 0);
		send_request(BAUD_W'(250000), 1'b0);
		send_request(BAUD_W'(0), 1'b1);

		set_config(CLOCK_W'(1000000), MAXERR_W'(10000), 0);
		send_request(BAUD_W'(1), 1'b0);
		send_request(BAUD_W'(300), 1'b0);
		send_request(BAUD_W'(0), 1'b1);
		send_request(BAUD_W'(1000000), 1'b0);

		set_config(CLOCK_W'(100000000), '1, 0);
		send_request(BAUD_W'(1), 1'b0);
		send_request('1, 1'b1);
		send_request(BAUD_W'(1000000), 1'b0);
		send_request('1, 1'b0);

		for (p = 0; p < PHASES; p++) begin
			case (p)
				0: begin hz = CLOCK_RESET; tol = MAXERR_RESET; end
				1: begin
					hz = CLOCK_W'(1000000);
					tol = MAXERR_W'($urandom_range(0, 10000));
				end
				2: begin hz = CLOCK_W'(100000000); tol = MAXERR_W'(10000); end
				3: begin hz = CLOCK_W'(18432000); tol = '0; end
				4: begin hz = CLOCK_W'($urandom); tol = MAXERR_W'($urandom); end
				5: begin hz = CLOCK_W'(11059200); tol = MAXERR_W'(50); end
				6: begin
					hz = CLOCK_W'($urandom_range(1000000, 100000000));
					tol = MAXERR_W'($urandom_range(0, 1000));
				end
				7: begin hz = '1; tol = '1; end
				8: begin
					hz = CLOCK_W'($urandom_range(0, 100000000));
					tol = MAXERR_W'($urandom);
				end
				default: begin hz = CLOCK_W'(14745600); tol = MAXERR_W'(300); end
			endcase
			set_config(hz, tol, p == 4 || p == 8);
			if (p < 4) begin
				send_idle_pct = 25;
				recv_idle_pct = 62;
			end else if (p < 7) begin
				send_idle_pct = 62;
				recv_idle_pct = 25;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			// The result side stops for a long stretch so that the input backs up.
			if (p == 0)
				hold_req = 1'b1;
			for (n = 0; n < PHASE_ITEMS; n++)
				send_request(random_baud(), $urandom_range(0, 99) < 25);
		end

		drain(200);
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
